[hw/rtl/sldq_pkg.sv]
// Shared types and constants for the sorted double-ended queue.
package sldq_pkg;

   localparam int CAPACITY = 64;
   localparam int WORD_WIDTH = 32;

   localparam logic signed [WORD_WIDTH-1:0] FAIL_WORD = {1'b1, {(WORD_WIDTH-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_INSERT     = 2'd0,
      OP_REMOVE_MIN = 2'd1,
      OP_REMOVE_MAX = 2'd2
   } sldq_op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } sldq_status_type;

   typedef struct packed {
      logic                         apply;
      sldq_op_type                  op;
      logic signed [WORD_WIDTH-1:0] value;
   } sldq_cmd_type;

   typedef struct packed {
      logic                         occ;
      logic                         lt;
      logic signed [WORD_WIDTH-1:0] entry;
   } sldq_cell_type;

endpackage

[hw/rtl/sorted_list_double_ended_queue.sv]
// Sorted double-ended queue built as a chain of compare-and-shift cells.
// The result is registered at the accepting edge and offered in the next cycle.
// Throughput: one transaction per cycle while the output side does not stall; every cell compares and shifts at once.
// A held result stalls the input only while the output side itself stalls.
// Synchronous reset empties the store and drops any pending result.
module sorted_list_double_ended_queue
   import sldq_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_op,
   input  logic signed [WORD_WIDTH-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [WORD_WIDTH-1:0] rsp_result_value,
   output logic [1:0]                   rsp_status
);

   sldq_cell_type                cells [CAPACITY];
   logic [CAPACITY-1:0]          occ_vec;
   logic [CAPACITY:0]            occ_plus_one;
   sldq_cmd_type                 cmd;
   logic                         accept;
   logic                         produce;
   logic                         full;
   logic                         empty;
   logic                         failed;
   logic signed [WORD_WIDTH-1:0] max_value;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic signed [WORD_WIDTH-1:0] rsp_result_value_ff;
   logic signed [WORD_WIDTH-1:0] rsp_result_value_in;
   sldq_status_type              rsp_status_ff;
   sldq_status_type              rsp_status_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = occ_vec[CAPACITY-1];
   assign empty     = !occ_vec[0];

   always_comb begin
      produce = 1'b0;
      failed  = 1'b0;
      unique case (sldq_op_type'(req_op)) inside
         OP_INSERT: begin
            produce = 1'b1;
            failed  = full;
         end
         OP_REMOVE_MIN, OP_REMOVE_MAX: begin
            produce = 1'b1;
            failed  = empty;
         end
         default: begin
            produce = 1'b0;
            failed  = 1'b0;
         end
      endcase
   end

   assign cmd.apply = accept && produce && !failed;
   assign cmd.op    = sldq_op_type'(req_op);
   assign cmd.value = req_value;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         sldq_cell_type left_cell;
         sldq_cell_type right_cell;
         if (gi == 0) begin : g_first
            assign left_cell = '{occ: 1'b1, lt: 1'b1, entry: '0};
         end else begin : g_inner_left
            assign left_cell = cells[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_last
            assign right_cell = '{occ: 1'b0, lt: 1'b0, entry: '0};
         end else begin : g_inner_right
            assign right_cell = cells[gi+1];
         end
         sldq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .left_cell  (left_cell),
            .right_cell (right_cell),
            .cell_out   (cells[gi])
         );
         assign occ_vec[gi] = cells[gi].occ;
      end
   endgenerate

   always_comb begin
      max_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (cells[i].occ && ((i == CAPACITY - 1) || !occ_vec[(i + 1) % CAPACITY])) begin
            max_value = max_value | cells[i].entry;
         end
      end
   end

   always_comb begin
      rsp_valid_in        = rsp_valid_ff;
      rsp_result_value_in = rsp_result_value_ff;
      rsp_status_in       = rsp_status_ff;
      if (accept && produce) begin
         rsp_valid_in = 1'b1;
         if (failed) begin
            rsp_result_value_in = FAIL_WORD;
            rsp_status_in       = (cmd.op == OP_INSERT) ? STATUS_FULL : STATUS_EMPTY;
         end else begin
            rsp_status_in = STATUS_OK;
            unique case (cmd.op)
               OP_INSERT:     rsp_result_value_in = req_value;
               OP_REMOVE_MIN: rsp_result_value_in = cells[0].entry;
               OP_REMOVE_MAX: rsp_result_value_in = max_value;
               default:       rsp_result_value_in = rsp_result_value_ff;
            endcase
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_value_ff <= rsp_result_value_in;
      rsp_status_ff       <= rsp_status_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_result_value_ff;
   assign rsp_status       = rsp_status_ff;

   assign occ_plus_one = {1'b0, occ_vec} + {{CAPACITY{1'b0}}, 1'b1};

   a_occ_prefix : assert property (@(posedge clock) disable iff (reset)
      $onehot(occ_plus_one))
      else $error("Occupied slots do not form a contiguous prefix.");

   a_insert_grows : assert property (@(posedge clock) disable iff (reset)
      (cmd.apply && cmd.op == OP_INSERT) |=>
      ($countones(occ_vec) == $past($countones(occ_vec)) + 1))
      else $error("Insert did not add exactly one entry.");

   a_remove_shrinks : assert property (@(posedge clock) disable iff (reset)
      (cmd.apply && (cmd.op == OP_REMOVE_MIN || cmd.op == OP_REMOVE_MAX)) |=>
      ($countones(occ_vec) + 1 == $past($countones(occ_vec))))
      else $error("Removal did not drop exactly one entry.");

   a_empty_status : assert property (@(posedge clock) disable iff (reset)
      (accept && empty && (cmd.op == OP_REMOVE_MIN || cmd.op == OP_REMOVE_MAX)) |=>
      (rsp_valid_ff && rsp_status_ff == STATUS_EMPTY))
      else $error("Removal from an empty store was not reported.");

   a_ordered_head : assert property (@(posedge clock) disable iff (reset)
      (cells[0].occ && cells[1].occ) |-> (cells[0].entry <= cells[1].entry))
      else $error("The two smallest entries are out of order.");

endmodule

[hw/rtl/sldq_cell.sv]
// One slot of the sorted chain, shifting entries to and from its neighbours.
module sldq_cell
   import sldq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  sldq_cmd_type  cmd,
   input  sldq_cell_type left_cell,
   input  sldq_cell_type right_cell,
   output sldq_cell_type cell_out
);

   logic signed [WORD_WIDTH-1:0] entry_ff;
   logic signed [WORD_WIDTH-1:0] entry_in;
   logic                         occ_ff;
   logic                         occ_in;

   always_comb begin
      entry_in = entry_ff;
      occ_in   = occ_ff;
      if (cmd.apply) begin
         unique case (cmd.op)
            OP_INSERT: begin
               occ_in = left_cell.occ;
               if (!cell_out.lt) begin
                  entry_in = left_cell.lt ? cmd.value : left_cell.entry;
               end
            end
            OP_REMOVE_MIN: begin
               entry_in = right_cell.entry;
               occ_in   = right_cell.occ;
            end
            OP_REMOVE_MAX: begin
               occ_in = occ_ff & right_cell.occ;
            end
            default: begin
               entry_in = entry_ff;
               occ_in   = occ_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign cell_out.occ   = occ_ff;
   assign cell_out.lt    = occ_ff && (entry_ff < cmd.value);
   assign cell_out.entry = entry_ff;

endmodule
